// File: rtl/lste_pkg.sv
// Shared types, constants and helpers for the linked set toggle engine
`timescale 1ns / 1ps

package lste_pkg;

  // node pool size, node 0 is the null link and never holds data
  localparam int CAPACITY = 64;
  localparam int NODE_W   = $clog2(CAPACITY);

  // command codes
  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_APPEND = 3'd1;
  localparam logic [2:0] CMD_TOGGLE = 3'd2;
  localparam logic [2:0] CMD_DUMP   = 3'd3;
  localparam logic [2:0] CMD_FIND   = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef logic [NODE_W-1:0] node_idx_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         node_index;
    logic signed [31:0] data_out;
    logic               last;
  } out_item_t;

  // one entry of the node memory
  typedef struct packed {
    logic signed [31:0] elem;
    node_idx_t          link;
  } node_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_LINK,
    S_CMP,
    S_DUMP,
    S_EMIT
  } lste_state_t;

  // free chain link of an entry that has not been written since clear
  function automatic node_idx_t free_init(input node_idx_t idx);
    node_idx_t nx;
    if (idx == NODE_W'(CAPACITY - 1)) begin
      nx = '0;
    end else begin
      nx = idx + NODE_W'(1);
    end
    return nx;
  endfunction

endpackage

// File: rtl/linked_set_toggle_engine.sv
// Linked set toggle engine: node list and free chain kept in synchronous memories
// Find and toggle walk the list from the head; a toggle that misses then appends the value,
// and a dump emits one result per node.
// Throughput: one request at a time; a find or toggle walk reads one node per cycle, while
// a dump is held by output stalls.
// Reset (synchronous, rst_n low): list empty, free chain rebuilt via valid bits, no result
`timescale 1ns / 1ps

module linked_set_toggle_engine
  import lste_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // node memory (element and list link) and free chain memory
  node_t     node_mem [CAPACITY];
  node_idx_t free_mem [CAPACITY];

  lste_state_t state_r, state_nxt;

  node_idx_t head_r, head_nxt;
  node_idx_t tail_r, tail_nxt;
  node_idx_t free_head_r, free_head_nxt;
  node_idx_t cur_r, cur_nxt;
  node_idx_t prev_r, prev_nxt;
  logic [2:0]         cmd_r, cmd_nxt;
  logic signed [31:0] val_r, val_nxt;
  out_item_t res_r, res_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_res_r;
  logic      out_load;

  logic [CAPACITY-1:0] free_vld_r;
  logic                free_clr;

  // memory access controls
  logic      node_re, node_we_full, node_we_link;
  node_idx_t node_raddr, node_waddr;
  node_t     node_wdata;
  node_t     node_q_r;

  logic      free_re, free_we;
  node_idx_t free_raddr, free_waddr, free_wdata;
  node_idx_t free_rd_r, free_dflt_r, free_q;
  logic      free_rd_vld_r;

  logic in_acc;
  logic out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_res_r;

  // free link as read, default chain where the entry was not written since clear
  assign free_q = free_rd_vld_r ? free_rd_r : free_dflt_r;

  // node memory
  always_ff @(posedge clk) begin
    if (node_we_full) begin
      node_mem[node_waddr] <= node_wdata;
    end else if (node_we_link) begin
      node_mem[node_waddr].link <= node_wdata.link;
    end
    if (node_re) begin
      node_q_r <= node_mem[node_raddr];
    end
  end

  // free chain memory
  always_ff @(posedge clk) begin
    if (free_we) begin
      free_mem[free_waddr] <= free_wdata;
    end
    if (free_re) begin
      free_rd_r     <= free_mem[free_raddr];
      free_rd_vld_r <= free_vld_r[free_raddr];
      free_dflt_r   <= free_init(free_raddr);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      free_head_r <= NODE_W'(1);
      free_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_head_r <= free_head_nxt;
      out_valid_r <= out_valid_nxt;
      if (free_clr) begin
        free_vld_r <= '0;
      end else if (free_we) begin
        free_vld_r[free_waddr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    cmd_r  <= cmd_nxt;
    val_r  <= val_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_res_r <= res_r;
    end
  end

  // next state, memory controls and results
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    free_head_nxt = free_head_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    cmd_nxt       = cmd_r;
    val_nxt       = val_r;
    res_nxt       = res_r;
    free_clr      = 1'b0;
    node_re       = 1'b0;
    node_raddr    = cur_r;
    node_we_full  = 1'b0;
    node_we_link  = 1'b0;
    node_waddr    = cur_r;
    node_wdata    = '{elem: val_r, link: '0};
    free_re       = 1'b0;
    free_raddr    = free_head_r;
    free_we       = 1'b0;
    free_waddr    = cur_r;
    free_wdata    = free_head_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = in_data.cmd;
          val_nxt  = in_data.value;
          prev_nxt = '0;
          cur_nxt  = head_r;
          res_nxt  = '{status: ST_OK, node_index: '0, data_out: in_data.value, last: 1'b1};
          case (in_data.cmd)
            CMD_CLEAR: begin
              head_nxt      = '0;
              tail_nxt      = '0;
              free_head_nxt = NODE_W'(1);
              free_clr      = 1'b1;
              state_nxt     = S_EMIT;
            end
            CMD_APPEND: begin
              state_nxt = S_TAKE;
            end
            CMD_TOGGLE, CMD_FIND: begin
              if (head_r != '0) begin
                node_re    = 1'b1;
                node_raddr = head_r;
                state_nxt  = S_CMP;
              end else if (in_data.cmd == CMD_TOGGLE) begin
                state_nxt = S_TAKE;
              end else begin
                res_nxt.status = ST_NOT_FOUND;
                state_nxt      = S_EMIT;
              end
            end
            CMD_DUMP: begin
              if (head_r != '0) begin
                node_re    = 1'b1;
                node_raddr = head_r;
                state_nxt  = S_DUMP;
              end else begin
                res_nxt.status = ST_EMPTY;
                state_nxt      = S_EMIT;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // pop the free chain head and write the new node, or report full when the chain is empty
      S_TAKE: begin
        if (free_head_r == '0) begin
          res_nxt   = '{status: ST_FULL, node_index: '0, data_out: val_r, last: 1'b1};
          state_nxt = S_EMIT;
        end else begin
          free_re      = 1'b1;
          free_raddr   = free_head_r;
          node_we_full = 1'b1;
          node_waddr   = free_head_r;
          cur_nxt      = free_head_r;
          state_nxt    = S_LINK;
        end
      end

      // hook the new node after the tail
      S_LINK: begin
        free_head_nxt = free_q;
        if (tail_r == '0) begin
          head_nxt = cur_r;
        end else begin
          node_we_link    = 1'b1;
          node_waddr      = tail_r;
          node_wdata.link = cur_r;
        end
        tail_nxt  = cur_r;
        res_nxt   = '{status: ST_OK, node_index: 6'(cur_r), data_out: val_r, last: 1'b1};
        state_nxt = S_EMIT;
      end

      // compare one node per cycle, read ahead to the next
      S_CMP: begin
        if (node_q_r.elem == val_r) begin
          if (cmd_r == CMD_FIND) begin
            res_nxt = '{status: ST_OK, node_index: 6'(cur_r), data_out: val_r, last: 1'b1};
          end else begin
            if (prev_r == '0) begin
              head_nxt = node_q_r.link;
            end else begin
              node_we_link    = 1'b1;
              node_waddr      = prev_r;
              node_wdata.link = node_q_r.link;
            end
            free_we       = 1'b1;
            free_waddr    = cur_r;
            free_wdata    = free_head_r;
            free_head_nxt = cur_r;
            if (tail_r == cur_r) begin
              tail_nxt = prev_r;
            end
            res_nxt = '{status: ST_REMOVED, node_index: 6'(cur_r), data_out: val_r,
                        last: 1'b1};
          end
          state_nxt = S_EMIT;
        end else if (node_q_r.link == '0) begin
          if (cmd_r == CMD_TOGGLE) begin
            state_nxt = S_TAKE;
          end else begin
            res_nxt   = '{status: ST_NOT_FOUND, node_index: '0, data_out: val_r, last: 1'b1};
            state_nxt = S_EMIT;
          end
        end else begin
          prev_nxt   = cur_r;
          cur_nxt    = node_q_r.link;
          node_re    = 1'b1;
          node_raddr = node_q_r.link;
        end
      end

      // format one dumped node
      S_DUMP: begin
        res_nxt = '{status: ST_OK, node_index: 6'(cur_r), data_out: node_q_r.elem,
                    last: (node_q_r.link == '0)};
        cur_nxt   = node_q_r.link;
        state_nxt = S_EMIT;
      end

      // hand the result to the output register
      S_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          if (cmd_r == CMD_DUMP && !res_r.last) begin
            node_re    = 1'b1;
            node_raddr = cur_r;
            state_nxt  = S_DUMP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // head and tail are zero together: the list is empty exactly when both are zero
  a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == '0) == (tail_r == '0))
    else $error("head and tail disagree on empty list");

  // an exhausted free chain means every node is on the list
  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (free_head_r == '0) |-> (head_r != '0))
    else $error("free chain empty while list empty");

  // output register only loads from the emit step
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result shown without emit step");

  // a removed result never names node zero
  a_removed_node: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status == ST_REMOVED) |-> (out_res_r.node_index != '0))
    else $error("removed result names node zero");

endmodule

// File: dv/tb_top.sv
// Testbench for the linked set toggle engine: random and directed requests against a list predictor
`timescale 1ns / 1ps

module tb_top
  import lste_pkg::*;
();

  // command codes the block ignores
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam int RANDOM_REQUESTS = 280;
  localparam int SETTLE_CYCLES   = 200;

  // mirror of the node list, the free chain and the results still owed
  class toggle_set_board;
    logic signed [31:0] elem_mem [CAPACITY];
    node_idx_t          next_link[CAPACITY];
    node_idx_t          free_next[CAPACITY];
    node_idx_t          tail_at;
    out_item_t          pending[$];
    int unsigned        errors, requests, results;
    int unsigned        dumps, longest_dump, removals, fulls, misses;

    function new();
      foreach (elem_mem[i]) begin
        elem_mem[i]  = '0;
        next_link[i] = '0;
      end
      rebuild_free();
      tail_at = '0;
    endfunction

    function void rebuild_free();
      foreach (free_next[i]) begin
        free_next[i] = (i == CAPACITY - 1) ? node_idx_t'(0) : node_idx_t'(i + 1);
      end
    endfunction

    function node_idx_t grab_free();
      node_idx_t n;
      n = free_next[0];
      if (n != '0) free_next[0] = free_next[n];
      return n;
    endfunction

    // link a new node after the tail, zero when the pool is exhausted
    function node_idx_t link_after_tail(logic signed [31:0] v);
      node_idx_t n;
      n = grab_free();
      if (n == '0) return '0;
      elem_mem[n]        = v;
      next_link[n]       = next_link[tail_at];
      next_link[tail_at] = n;
      tail_at            = n;
      return n;
    endfunction

    // walk from the head, bounded by the pool size
    function node_idx_t locate(logic signed [31:0] v, output node_idx_t prev);
      node_idx_t p, k;
      int        steps;
      p     = '0;
      k     = next_link[0];
      steps = 0;
      while (k != '0 && elem_mem[k] != v && steps < CAPACITY) begin
        p = k;
        k = next_link[k];
        steps++;
      end
      if (k != '0 && elem_mem[k] != v) k = '0;
      prev = p;
      return k;
    endfunction

    function void queue_result(logic [2:0] st, node_idx_t node, logic signed [31:0] data,
                               logic fin);
      out_item_t e;
      e.status     = st;
      e.node_index = node;
      e.data_out   = data;
      e.last       = fin;
      pending.push_back(e);
      if (st == ST_FULL) fulls++;
      if (st == ST_REMOVED) removals++;
      if (st == ST_NOT_FOUND) misses++;
    endfunction

    // work out every result one accepted request causes
    function void note_request(in_item_t req);
      node_idx_t n, p, nx;
      int        cnt;
      requests++;
      case (req.cmd)
        CMD_CLEAR: begin
          rebuild_free();
          next_link[0] = '0;
          tail_at      = '0;
          queue_result(ST_OK, '0, req.value, 1'b1);
        end
        CMD_APPEND: begin
          n = link_after_tail(req.value);
          queue_result((n != '0) ? ST_OK : ST_FULL, n, req.value, 1'b1);
        end
        CMD_TOGGLE: begin
          n = locate(req.value, p);
          if (n == '0) begin
            n = link_after_tail(req.value);
            queue_result((n != '0) ? ST_OK : ST_FULL, n, req.value, 1'b1);
          end else begin
            // unlink, push on the free chain, pull the tail back if needed
            next_link[p] = next_link[n];
            free_next[n] = free_next[0];
            free_next[0] = n;
            if (tail_at == n) tail_at = p;
            queue_result(ST_REMOVED, n, req.value, 1'b1);
          end
        end
        CMD_DUMP: begin
          dumps++;
          n = next_link[0];
          if (n == '0) begin
            queue_result(ST_EMPTY, '0, req.value, 1'b1);
          end else begin
            cnt = 0;
            while (n != '0 && cnt < CAPACITY - 1) begin
              nx = next_link[n];
              queue_result(ST_OK, n, elem_mem[n], (nx == '0) || (cnt + 1 >= CAPACITY - 1));
              cnt++;
              n = nx;
            end
            if (cnt > longest_dump) longest_dump = cnt;
          end
        end
        CMD_FIND: begin
          n = locate(req.value, p);
          queue_result((n != '0) ? ST_OK : ST_NOT_FOUND, n, req.value, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void match_field(string fname, logic [31:0] want, logic [31:0] got_v);
      if (want !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, fname, want, got_v);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual status %0d node %0d data %h last %b",
                 $time, got.status, got.node_index, got.data_out, got.last);
        return;
      end
      want = pending.pop_front();
      results++;
      match_field("status", 32'(want.status), 32'(got.status));
      match_field("node_index", 32'(want.node_index), 32'(got.node_index));
      match_field("data_out", want.data_out, got.data_out);
      match_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  toggle_set_board sb = new();
  bit          calm;
  int unsigned req_sent;
  int unsigned stall_left;

  linked_set_toggle_engine u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly short gaps, a few long ones, none during calm stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // small pool so toggles and finds hit, plus extremes and full-range values
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
      1, 2: return $urandom;
      default: return int'($urandom_range(0, 23)) - 12;
    endcase
  endfunction

  function automatic logic [2:0] pick_spare();
    case ($urandom_range(0, 2))
      0: return CMD_SPARE_A;
      1: return CMD_SPARE_B;
      default: return CMD_SPARE_C;
    endcase
  endfunction

  // drive one request and wait for it to be taken
  task automatic send_request(input logic [2:0] c, input logic signed [31:0] v);
    int unsigned gap;
    in_item_t    req;
    req.cmd   = c;
    req.value = v;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
    req_sent++;
  endtask

  // one well-formed pass: maybe clear, build set a, toggle set b, look up, dump
  task automatic run_episode(input bit fill_up);
    logic signed [31:0] vals[$];
    logic signed [31:0] v;
    int unsigned        k;
    if (fill_up || $urandom_range(0, 9) < 7) send_request(CMD_CLEAR, pick_value());
    k = fill_up ? CAPACITY + 1 : $urandom_range(1, 10);
    repeat (k) begin
      v = pick_value();
      vals.push_back(v);
      send_request(CMD_APPEND, v);
    end
    repeat ($urandom_range(1, 10)) begin
      if ($urandom_range(0, 1)) v = vals[$urandom_range(0, vals.size() - 1)];
      else v = pick_value();
      send_request(CMD_TOGGLE, v);
    end
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 1)) v = vals[$urandom_range(0, vals.size() - 1)];
      else v = pick_value();
      send_request(CMD_FIND, v);
    end
    send_request(CMD_DUMP, pick_value());
  endtask

  // result side stall pattern
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall  <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // compare every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // stimulus and end of run
  initial begin
    int unsigned episode, waited;
    bit          filled;
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    calm     = 1'b0;
    req_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: empty list, extremes, head/middle/tail removal, ignored codes
    send_request(CMD_DUMP, VAL_MAX);
    send_request(CMD_FIND, VAL_MIN);
    send_request(CMD_TOGGLE, VAL_MIN);
    send_request(CMD_APPEND, 32'sd0);
    send_request(CMD_APPEND, -32'sd1);
    send_request(CMD_APPEND, VAL_MAX);
    send_request(CMD_FIND, 32'sd0);
    send_request(CMD_DUMP, 32'sd0);
    send_request(CMD_TOGGLE, VAL_MIN);
    send_request(CMD_TOGGLE, VAL_MAX);
    send_request(CMD_APPEND, 32'sd5);
    send_request(CMD_TOGGLE, -32'sd1);
    send_request(CMD_DUMP, -32'sd1);
    send_request(CMD_SPARE_A, VAL_MAX);
    send_request(CMD_SPARE_B, VAL_MIN);
    send_request(CMD_SPARE_C, -32'sd1);
    send_request(CMD_CLEAR, 32'sh5555_5555);
    send_request(CMD_DUMP, 32'shaaaa_aaaa);
    send_request(CMD_APPEND, 32'shaaaa_aaaa);
    send_request(CMD_TOGGLE, 32'shaaaa_aaaa);
    send_request(CMD_TOGGLE, 32'shaaaa_aaaa);
    send_request(CMD_FIND, 32'shaaaa_aaaa);
    send_request(CMD_DUMP, 32'sh5555_5555);

    // random: mostly set-difference passes, one filling the pool, some noise
    episode = 0;
    filled  = 1'b0;
    while (req_sent < RANDOM_REQUESTS || !filled) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) send_request(3'($urandom), pick_value());
      end else begin
        run_episode(episode == 3);
        if (episode == 3) filled = 1'b1;
        episode++;
      end
    end
    calm = 1'b0;
    @(negedge clk) in_valid <= 1'b0;

    // drain and let the block settle
    waited = 0;
    while (sb.pending.size() != 0 && waited < 1000000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.pending.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
    $display("Ran %0d requests and checked %0d results over %0d dumps (longest %0d nodes)",
             sb.requests, sb.results, sb.dumps, sb.longest_dump);
    $display("Saw %0d removals, %0d full rejections, %0d failed lookups",
             sb.removals, sb.fulls, sb.misses);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hard stop
  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
